FILE: rtl/rc6_block_cipher_core_macros.svh
// ----------------------------------------------------------------------------
// RC6 core assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RC6_BLOCK_CIPHER_CORE_MACROS_SVH
`define RC6_BLOCK_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RC6_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RC6_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rc6_pkg.sv
// ----------------------------------------------------------------------------
// RC6 package
// Shared constants, operation and register codes, and word helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rc6_pkg;

    localparam int WORD_W        = 32;
    localparam int KEY_REG_W     = 64;
    localparam int KEY_LEN_W     = 6;
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int ROUNDS_DEF    = 20;
    localparam int MAX_KEY_BYTES_DEF = 32;

    localparam logic [WORD_W-1:0] P_CONST = 32'hB7E15163;
    localparam logic [WORD_W-1:0] Q_CONST = 32'h9E3779B9;

    localparam logic [OP_W-1:0] OP_EXPAND  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN      = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    function automatic logic [WORD_W-1:0] rc6_rol(input logic [WORD_W-1:0] x,
                                                  input logic [4:0] n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rc6_ror(input logic [WORD_W-1:0] x,
                                                  input logic [4:0] n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} >> n;
        return w[WORD_W-1:0];
    endfunction

    // f(x) = (x * (2x + 1)) <<< 5, kept to the low word of the product.
    function automatic logic [WORD_W-1:0] rc6_mix(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] p;
        p = x * {x[WORD_W-2:0], 1'b1};
        return rc6_rol(p, 5'd5);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rc6_key_ram.sv
// ----------------------------------------------------------------------------
// RC6 round-key memory
// Round keys stored as even and odd words side by side; one write port with
// a per-half enable and one registered read port returning both halves.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_key_ram #(
    parameter int ROWS = rc6_pkg::ROUNDS_DEF + 2
) (
    input  wire logic                          i_clk,
    input  wire logic [$clog2(ROWS)-1:0]       i_rd_row,
    input  wire logic [1:0]                    i_wr_en,
    input  wire logic [$clog2(ROWS)-1:0]       i_wr_row,
    input  wire logic [rc6_pkg::WORD_W-1:0]    i_wr_data,
    output logic      [rc6_pkg::WORD_W-1:0]    o_rd_even,
    output logic      [rc6_pkg::WORD_W-1:0]    o_rd_odd
);
    import rc6_pkg::*;

    logic [WORD_W-1:0] r_even [ROWS];
    logic [WORD_W-1:0] r_odd  [ROWS];
    logic [WORD_W-1:0] r_rd_even;
    logic [WORD_W-1:0] r_rd_odd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en[0]) begin
            r_even[i_wr_row] <= i_wr_data;
        end
        if (i_wr_en[1]) begin
            r_odd[i_wr_row] <= i_wr_data;
        end
        r_rd_even <= r_even[i_rd_row];
        r_rd_odd  <= r_odd[i_rd_row];
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;

endmodule

`default_nettype wire

FILE: rtl/rc6_block_cipher_core.sv
// ----------------------------------------------------------------------------
// RC6 block cipher core
// RC6 with 32-bit words: key expansion into a round-key memory, and
// single-block encryption and decryption on a shared round datapath.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_stall       i_operation, i_block_word_0..3
//   output    out        o_out_valid / i_out_stall     o_result_word_0..3
//   config    in         i_cfg_we                      i_cfg_index, i_cfg_wdata
//
// A block passes through an entry whitening step, then for each round a
// multiply step for f() followed by a rotate-and-add step, then an exit
// whitening step.
// Key expansion first writes the table one word a cycle through the single
// memory write port; each mixing step then updates the table word and after
// it the key word.
// Reset is synchronous; the round-key table reads as all zero until the first
// expansion has filled it. A finished block waits in its exit step while the
// output register still holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc6_block_cipher_core_macros.svh"

module rc6_block_cipher_core #(
    parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
    parameter int MAX_KEY_BYTES = rc6_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [rc6_pkg::OP_W-1:0]        i_operation,
    input  wire logic [rc6_pkg::WORD_W-1:0]      i_block_word_0,
    input  wire logic [rc6_pkg::WORD_W-1:0]      i_block_word_1,
    input  wire logic [rc6_pkg::WORD_W-1:0]      i_block_word_2,
    input  wire logic [rc6_pkg::WORD_W-1:0]      i_block_word_3,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [rc6_pkg::WORD_W-1:0]      o_result_word_0,
    output logic      [rc6_pkg::WORD_W-1:0]      o_result_word_1,
    output logic      [rc6_pkg::WORD_W-1:0]      o_result_word_2,
    output logic      [rc6_pkg::WORD_W-1:0]      o_result_word_3,

    input  wire logic                            i_cfg_we,
    input  wire logic [rc6_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rc6_pkg::KEY_REG_W-1:0]   i_cfg_wdata
);
    import rc6_pkg::*;

    localparam int T_WORDS  = 2 * ROUNDS + 4;
    localparam int ROWS     = ROUNDS + 2;
    localparam int RW       = $clog2(ROWS);
    localparam int IW       = RW + 1;
    localparam int KW       = (MAX_KEY_BYTES + 3) / 4;
    localparam int JW       = (KW > 1) ? $clog2(KW) : 1;
    localparam int MAX_W    = (T_WORDS > KW) ? T_WORDS : KW;
    localparam int SW       = $clog2(3 * MAX_W + 1);
    localparam int KEY_ALL_W = 4 * KEY_REG_W;

    localparam logic [RW-1:0] ROW_FIRST = '0;
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROUNDS + 1);
    localparam logic [RW-1:0] ROUND_MAX = RW'(ROUNDS);
    localparam logic [RW-1:0] ROUND_MIN = RW'(1);
    localparam logic [IW-1:0] KI_LAST   = IW'(T_WORDS - 1);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STATE_W-1:0] S_PRE    = 4'd1;
    localparam logic [STATE_W-1:0] S_MIX    = 4'd2;
    localparam logic [STATE_W-1:0] S_UPD    = 4'd3;
    localparam logic [STATE_W-1:0] S_POST   = 4'd4;
    localparam logic [STATE_W-1:0] S_KINIT  = 4'd5;
    localparam logic [STATE_W-1:0] S_KPRIME = 4'd6;
    localparam logic [STATE_W-1:0] S_KA     = 4'd7;
    localparam logic [STATE_W-1:0] S_KB     = 4'd8;

    // Configuration registers
    logic [KEY_REG_W-1:0] r_key [4];
    logic [KEY_LEN_W-1:0] r_key_len;

    // Control
    logic [STATE_W-1:0] r_state, n_state;
    logic               r_dec, n_dec;
    logic [RW-1:0]      r_round, n_round;
    logic [IW-1:0]      r_ki, n_ki;
    logic [JW-1:0]      r_kj, n_kj;
    logic [JW-1:0]      r_words_m1, n_words_m1;
    logic [SW-1:0]      r_steps, n_steps;
    logic               r_loaded, n_loaded;
    logic               r_out_valid, n_out_valid;

    // Datapath
    logic [WORD_W-1:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [WORD_W-1:0] r_t, n_t, r_u, n_u;
    logic [WORD_W-1:0] r_sacc, n_sacc;
    logic [WORD_W-1:0] r_out [4];
    logic [WORD_W-1:0] n_out [4];
    logic [WORD_W-1:0] r_scratch [KW];

    // Memory port
    logic [RW-1:0]     ram_rd_row;
    logic [1:0]        ram_wr_en;
    logic [RW-1:0]     ram_wr_row;
    logic [WORD_W-1:0] ram_wr_data;
    logic [WORD_W-1:0] ram_rd_even, ram_rd_odd;
    logic [WORD_W-1:0] key_even, key_odd, key_sel;

    // Expansion helpers
    logic [KEY_ALL_W-1:0] key_all;
    logic [KEY_LEN_W-1:0] len_sat;
    logic [KEY_LEN_W-1:0] words;
    logic [SW-1:0]        step_words;
    logic [WORD_W-1:0]    scr_init [KW];
    logic                 scr_load;
    logic                 scr_wr;
    logic [WORD_W-1:0]    kab, a_new, b_new, ab_sum;

    // Round helpers
    logic [WORD_W-1:0] enc_a, enc_c, dec_a, dec_c;
    logic              last_round;
    logic              out_free;

    rc6_key_ram #(
        .ROWS (ROWS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_rd_row  (ram_rd_row),
        .i_wr_en   (ram_wr_en),
        .i_wr_row  (ram_wr_row),
        .i_wr_data (ram_wr_data),
        .o_rd_even (ram_rd_even),
        .o_rd_odd  (ram_rd_odd)
    );

    // Until the first expansion has filled the memory the table reads as zero.
    assign key_even = r_loaded ? ram_rd_even : '0;
    assign key_odd  = r_loaded ? ram_rd_odd  : '0;
    assign key_sel  = r_ki[0] ? key_odd : key_even;

    // Key bytes into little-endian words, bytes past the key length zeroed.
    assign key_all = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign len_sat = (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                     KEY_LEN_W'(MAX_KEY_BYTES) : r_key_len;
    assign words   = (len_sat == '0) ? KEY_LEN_W'(1) : ((len_sat + KEY_LEN_W'(3)) >> 2);
    assign step_words = (SW'(words) > SW'(T_WORDS)) ? SW'(words) : SW'(T_WORDS);

    always_comb begin
        for (int w = 0; w < KW; w++) begin
            for (int b = 0; b < 4; b++) begin
                scr_init[w][8*b +: 8] = (KEY_LEN_W'(4*w + b) < len_sat) ?
                                        key_all[8*(4*w + b) +: 8] : 8'h00;
            end
        end
    end

    // Mixing step arithmetic
    assign kab    = key_sel + r_a + r_b;
    assign a_new  = rc6_rol(kab, 5'd3);
    assign ab_sum = r_a + r_b;
    assign b_new  = rc6_rol(r_scratch[r_kj] + ab_sum, ab_sum[4:0]);

    // Round arithmetic
    assign enc_a = rc6_rol(r_a ^ r_t, r_u[4:0]) + key_even;
    assign enc_c = rc6_rol(r_c ^ r_u, r_t[4:0]) + key_odd;
    assign dec_c = rc6_ror(r_c - key_odd, r_t[4:0]) ^ r_u;
    assign dec_a = rc6_ror(r_a - key_even, r_u[4:0]) ^ r_t;
    assign last_round = r_dec ? (r_round == ROUND_MIN) : (r_round == ROUND_MAX);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_dec       = r_dec;
        n_round     = r_round;
        n_ki        = r_ki;
        n_kj        = r_kj;
        n_words_m1  = r_words_m1;
        n_steps     = r_steps;
        n_loaded    = r_loaded;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_t         = r_t;
        n_u         = r_u;
        n_sacc      = r_sacc;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_rd_row  = r_ki[IW-1:1];
        ram_wr_en   = 2'b00;
        ram_wr_row  = r_ki[IW-1:1];
        ram_wr_data = r_sacc;
        scr_load    = 1'b0;
        scr_wr      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_EXPAND: begin
                            scr_load   = 1'b1;
                            n_words_m1 = JW'(words - KEY_LEN_W'(1));
                            n_steps    = step_words + (step_words << 1);
                            n_ki       = '0;
                            n_sacc     = P_CONST;
                            n_state    = S_KINIT;
                        end
                        OP_ENCRYPT: begin
                            n_a        = i_block_word_0;
                            n_b        = i_block_word_1;
                            n_c        = i_block_word_2;
                            n_d        = i_block_word_3;
                            n_dec      = 1'b0;
                            n_round    = ROUND_MIN;
                            ram_rd_row = ROW_FIRST;
                            n_state    = S_PRE;
                        end
                        OP_DECRYPT: begin
                            n_a        = i_block_word_0;
                            n_b        = i_block_word_1;
                            n_c        = i_block_word_2;
                            n_d        = i_block_word_3;
                            n_dec      = 1'b1;
                            n_round    = ROUND_MAX;
                            ram_rd_row = ROW_LAST;
                            n_state    = S_PRE;
                        end
                        default: begin
                            // An unused code is consumed and produces nothing.
                        end
                    endcase
                end
            end
            S_PRE: begin
                if (r_dec) begin
                    n_a = r_a - key_even;
                    n_c = r_c - key_odd;
                end else begin
                    n_b = r_b + key_even;
                    n_d = r_d + key_odd;
                end
                n_state = S_MIX;
            end
            S_MIX: begin
                ram_rd_row = r_round;
                if (r_dec) begin
                    // The decryption round rotates the words before f() is taken.
                    n_a = r_d;
                    n_b = r_a;
                    n_c = r_b;
                    n_d = r_c;
                    n_t = rc6_mix(r_a);
                    n_u = rc6_mix(r_c);
                end else begin
                    n_t = rc6_mix(r_b);
                    n_u = rc6_mix(r_d);
                end
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_dec) begin
                    n_a = dec_a;
                    n_c = dec_c;
                end else begin
                    n_a = r_b;
                    n_b = enc_c;
                    n_c = r_d;
                    n_d = enc_a;
                end
                if (last_round) begin
                    ram_rd_row = r_dec ? ROW_FIRST : ROW_LAST;
                    n_state    = S_POST;
                end else begin
                    n_round = r_dec ? (r_round - ROUND_MIN) : (r_round + ROUND_MIN);
                    n_state = S_MIX;
                end
            end
            S_POST: begin
                ram_rd_row = r_dec ? ROW_FIRST : ROW_LAST;
                if (out_free) begin
                    if (r_dec) begin
                        n_out[0] = r_a;
                        n_out[1] = r_b - key_even;
                        n_out[2] = r_c;
                        n_out[3] = r_d - key_odd;
                    end else begin
                        n_out[0] = r_a + key_even;
                        n_out[1] = r_b;
                        n_out[2] = r_c + key_odd;
                        n_out[3] = r_d;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_KINIT: begin
                ram_wr_en   = r_ki[0] ? 2'b10 : 2'b01;
                ram_wr_data = r_sacc;
                n_sacc      = r_sacc + Q_CONST;
                if (r_ki == KI_LAST) begin
                    n_ki     = '0;
                    n_kj     = '0;
                    n_a      = '0;
                    n_b      = '0;
                    n_loaded = 1'b1;
                    n_state  = S_KPRIME;
                end else begin
                    n_ki = r_ki + IW'(1);
                end
            end
            S_KPRIME: begin
                // Read of the first table word is in flight.
                n_state = S_KA;
            end
            S_KA: begin
                ram_wr_en   = r_ki[0] ? 2'b10 : 2'b01;
                ram_wr_data = a_new;
                n_a         = a_new;
                n_ki        = (r_ki == KI_LAST) ? '0 : (r_ki + IW'(1));
                n_state     = S_KB;
            end
            S_KB: begin
                scr_wr  = 1'b1;
                n_b     = b_new;
                n_kj    = (r_kj == r_words_m1) ? '0 : (r_kj + JW'(1));
                n_steps = r_steps - SW'(1);
                n_state = (r_steps == SW'(1)) ? S_IDLE : S_KA;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dec       <= 1'b0;
            r_round     <= '0;
            r_ki        <= '0;
            r_kj        <= '0;
            r_words_m1  <= '0;
            r_steps     <= '0;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_key[3]    <= '0;
            r_key_len   <= KEY_LEN_RESET;
        end else begin
            r_state     <= n_state;
            r_dec       <= n_dec;
            r_round     <= n_round;
            r_ki        <= n_ki;
            r_kj        <= n_kj;
            r_words_m1  <= n_words_m1;
            r_steps     <= n_steps;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_LOW:      r_key[0]  <= i_cfg_wdata;
                    CFG_KEY_MID_LOW:  r_key[1]  <= i_cfg_wdata;
                    CFG_KEY_MID_HIGH: r_key[2]  <= i_cfg_wdata;
                    CFG_KEY_HIGH:     r_key[3]  <= i_cfg_wdata;
                    CFG_KEY_LEN:      r_key_len <= i_cfg_wdata[KEY_LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_t    <= n_t;
        r_u    <= n_u;
        r_sacc <= n_sacc;
        r_out  <= n_out;
    end

    // Key word scratch: loaded whole at the start of expansion, then one
    // word per mixing step.
    always_ff @(posedge i_clk) begin
        if (scr_load) begin
            r_scratch <= scr_init;
        end else if (scr_wr) begin
            r_scratch[r_kj] <= b_new;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_word_0 = r_out[0];
    assign o_result_word_1 = r_out[1];
    assign o_result_word_2 = r_out[2];
    assign o_result_word_3 = r_out[3];

    `RC6_ASSERT_NEXT(a_round_phases, i_clk, i_rst_n, r_state == S_MIX, r_state == S_UPD, "round multiply phase not followed by update phase")
    `RC6_ASSERT_IMPLIES(a_round_range, i_clk, i_rst_n, (r_state == S_MIX) || (r_state == S_UPD), (r_round >= ROUND_MIN) && (r_round <= ROUND_MAX), "round counter out of range")
    `RC6_ASSERT_IMPLIES(a_mix_index, i_clk, i_rst_n, (r_state == S_KA) || (r_state == S_KB), (r_ki <= KI_LAST) && (r_kj <= r_words_m1), "key mixing index out of range")
    `RC6_ASSERT_IMPLIES(a_result_source, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_POST, "result presented outside the exit step")

endmodule

`default_nettype wire

FILE: tb/rc6_block_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// RC6 block cipher core testbench
// Drives key expansion, encryption and decryption transactions through the
// core. Expected blocks are predicted from a local round-key schedule and
// compared word by word against every result the core returns. The run goes
// through several key settings and sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc6_block_cipher_core_tb;

    import rc6_pkg::*;

    localparam int ROUNDS          = ROUNDS_DEF;
    localparam int MAX_KEY_BYTES   = MAX_KEY_BYTES_DEF;
    localparam int TABLE_WORDS     = 2 * ROUNDS + 4;
    localparam int SCRATCH_WORDS   = (MAX_KEY_BYTES + 3) / 4;
    localparam int BLOCK_CYCLES    = 2 * ROUNDS + 3;
    localparam int EXPAND_CYCLES   = 2 * ROUNDS + 6 + 6 * TABLE_WORDS;
    localparam int SETTLE_CYCLES   = EXPAND_CYCLES + 2 * BLOCK_CYCLES;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASE_BLOCKS    = 235;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
    } block_t;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_operation    = OP_EXPAND;
    logic [WORD_W-1:0]    i_block_word_0 = '0;
    logic [WORD_W-1:0]    i_block_word_1 = '0;
    logic [WORD_W-1:0]    i_block_word_2 = '0;
    logic [WORD_W-1:0]    i_block_word_3 = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [WORD_W-1:0]    o_result_word_0;
    logic [WORD_W-1:0]    o_result_word_1;
    logic [WORD_W-1:0]    o_result_word_2;
    logic [WORD_W-1:0]    o_result_word_3;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_KEY_LOW;
    logic [KEY_REG_W-1:0] i_cfg_wdata    = '0;

    // Local copy of the key registers and round-key schedule.
    logic [KEY_REG_W-1:0] key_bytes [4];
    logic [KEY_LEN_W-1:0] key_len;
    logic [WORD_W-1:0]    round_keys [TABLE_WORDS];

    block_t expected_blocks [$];
    block_t last_ciphertext;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int cycle_count        = 0;
    bit hold_off_request   = 1'b0;
    int hold_off_left      = 0;

    rc6_block_cipher_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_block_word_0  (i_block_word_0),
        .i_block_word_1  (i_block_word_1),
        .i_block_word_2  (i_block_word_2),
        .i_block_word_3  (i_block_word_3),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_word_0 (o_result_word_0),
        .o_result_word_1 (o_result_word_1),
        .o_result_word_2 (o_result_word_2),
        .o_result_word_3 (o_result_word_3),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] n);
        if (n == 5'd0) begin
            return x;
        end
        return (x << n) | (x >> (32 - int'(n)));
    endfunction

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] n);
        if (n == 5'd0) begin
            return x;
        end
        return (x >> n) | (x << (32 - int'(n)));
    endfunction

    function automatic logic [WORD_W-1:0] quad_mix(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] p;
        p = x * ((x << 1) + 32'd1);
        return rotl32(p, 5'd5);
    endfunction

    function automatic void run_key_schedule();
        int unsigned       len;
        int unsigned       nwords;
        int unsigned       steps;
        int unsigned       ti;
        int unsigned       kj;
        logic [WORD_W-1:0] kw [SCRATCH_WORDS];
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [7:0]        kbyte;
        len = key_len;
        if (len > MAX_KEY_BYTES) begin
            len = MAX_KEY_BYTES;
        end
        nwords = (len + 3) / 4;
        if (nwords == 0) begin
            nwords = 1;
        end
        for (int k = 0; k < SCRATCH_WORDS; k++) begin
            kw[k] = '0;
        end
        for (int k = 0; k < len; k++) begin
            kbyte = key_bytes[(k >> 3) & 3][(k % 8) * 8 +: 8];
            kw[k / 4] = kw[k / 4] | (WORD_W'(kbyte) << ((k % 4) * 8));
        end
        round_keys[0] = P_CONST;
        for (int k = 1; k < TABLE_WORDS; k++) begin
            round_keys[k] = round_keys[k - 1] + Q_CONST;
        end
        steps = 3 * ((nwords > TABLE_WORDS) ? nwords : TABLE_WORDS);
        a = '0;
        b = '0;
        ti = 0;
        kj = 0;
        for (int s = 0; s < steps; s++) begin
            a = rotl32(round_keys[ti] + a + b, 5'd3);
            round_keys[ti] = a;
            b = rotl32(kw[kj] + a + b, 5'((a + b) & 32'h1F));
            kw[kj] = b;
            ti = (ti + 1) % TABLE_WORDS;
            kj = (kj + 1) % nwords;
        end
    endfunction

    function automatic block_t predict_encrypt(input block_t blk);
        logic [WORD_W-1:0] a, b, c, d, t, u, x;
        block_t            res;
        a = blk.word0;
        b = blk.word1 + round_keys[0];
        c = blk.word2;
        d = blk.word3 + round_keys[1];
        for (int r = 1; r <= ROUNDS; r++) begin
            t = quad_mix(b);
            u = quad_mix(d);
            a = rotl32(a ^ t, u[4:0]) + round_keys[2 * r];
            c = rotl32(c ^ u, t[4:0]) + round_keys[2 * r + 1];
            x = a;
            a = b;
            b = c;
            c = d;
            d = x;
        end
        res.word0 = a + round_keys[2 * ROUNDS + 2];
        res.word1 = b;
        res.word2 = c + round_keys[2 * ROUNDS + 3];
        res.word3 = d;
        return res;
    endfunction

    function automatic block_t predict_decrypt(input block_t blk);
        logic [WORD_W-1:0] a, b, c, d, t, u, x;
        block_t            res;
        a = blk.word0 - round_keys[2 * ROUNDS + 2];
        b = blk.word1;
        c = blk.word2 - round_keys[2 * ROUNDS + 3];
        d = blk.word3;
        for (int r = ROUNDS; r >= 1; r--) begin
            x = d;
            d = c;
            c = b;
            b = a;
            a = x;
            u = quad_mix(d);
            t = quad_mix(b);
            c = rotr32(c - round_keys[2 * r + 1], t[4:0]) ^ u;
            a = rotr32(a - round_keys[2 * r], u[4:0]) ^ t;
        end
        res.word0 = a;
        res.word1 = b - round_keys[0];
        res.word2 = c;
        res.word3 = d - round_keys[1];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic block_t make_block(input logic [WORD_W-1:0] w0,
                                          input logic [WORD_W-1:0] w1,
                                          input logic [WORD_W-1:0] w2,
                                          input logic [WORD_W-1:0] w3);
        block_t blk;
        blk.word0 = w0;
        blk.word1 = w1;
        blk.word2 = w2;
        blk.word3 = w3;
        return blk;
    endfunction

    // Mostly uniform words, with extremes and single-bit values mixed in.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic block_t rand_block();
        return make_block(rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    // Offers one transaction and returns in the step in which it was taken,
    // leaving valid high; the caller drives the next item or lowers valid.
    task automatic send_item(input logic [OP_W-1:0] op, input block_t blk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_block_word_0 <= blk.word0;
        i_block_word_1 <= blk.word1;
        i_block_word_2 <= blk.word2;
        i_block_word_3 <= blk.word3;
        do @(posedge i_clk); while (o_in_stall);
        case (op)
            OP_EXPAND: begin
                run_key_schedule();
            end
            OP_ENCRYPT: begin
                last_ciphertext = predict_encrypt(blk);
                expected_blocks.push_back(last_ciphertext);
            end
            OP_DECRYPT: begin
                expected_blocks.push_back(predict_decrypt(blk));
            end
            default: begin
            end
        endcase
    endtask

    // Waits for every outstanding result, then long enough for an expansion
    // in flight to finish, so that the registers may be rewritten.
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [KEY_REG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_KEY_LOW:      key_bytes[0] = data;
            CFG_KEY_MID_LOW:  key_bytes[1] = data;
            CFG_KEY_MID_HIGH: key_bytes[2] = data;
            CFG_KEY_HIGH:     key_bytes[3] = data;
            CFG_KEY_LEN:      key_len = data[KEY_LEN_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_key_config(input logic [KEY_REG_W-1:0] b0,
                                   input logic [KEY_REG_W-1:0] b1,
                                   input logic [KEY_REG_W-1:0] b2,
                                   input logic [KEY_REG_W-1:0] b3,
                                   input logic [KEY_LEN_W-1:0] len);
        write_reg(CFG_KEY_LOW, b0);
        write_reg(CFG_KEY_MID_LOW, b1);
        write_reg(CFG_KEY_MID_HIGH, b2);
        write_reg(CFG_KEY_HIGH, b3);
        write_reg(CFG_KEY_LEN, KEY_REG_W'(len));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_REG_W-1:0] rand_key_reg();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Blocks before any expansion run against the all-zero schedule.
    task automatic test_unkeyed_blocks();
        send_item(OP_ENCRYPT, make_block('0, '0, '0, '0));
        send_item(OP_ENCRYPT, make_block('1, '1, '1, '1));
        send_item(OP_DECRYPT, make_block(32'h8000_0000, 32'd1, '1, '0));
        send_item(OP_DECRYPT, make_block('0, '0, '0, '0));
        wait_for_idle();
    endtask

    task automatic test_unused_operation();
        send_item(OP_UNUSED, make_block('1, '1, '1, '1));
        send_item(OP_ENCRYPT, make_block(32'h0123_4567, 32'h89AB_CDEF, '1, '0));
        wait_for_idle();
    endtask

    task automatic test_key_length_extremes();
        // All-zero sixteen-byte key, the usual first test vector.
        load_key_config('0, '0, '0, '0, KEY_LEN_RESET);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_ENCRYPT, make_block('0, '0, '0, '0));
        wait_for_idle();

        load_key_config('1, '1, '1, '1, 6'd32);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_ENCRYPT, make_block('1, '1, '1, '1));
        send_item(OP_DECRYPT, last_ciphertext);
        wait_for_idle();

        // A zero length turns the key into a single zero word.
        load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                        rand_key_reg(), 6'd0);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_ENCRYPT, make_block(32'h8000_0000, 32'd1, '0, '1));
        wait_for_idle();

        // Lengths past the key store saturate.
        load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                        rand_key_reg(), 6'd63);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_ENCRYPT, make_block('1, '0, '1, '0));
        wait_for_idle();

        load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                        rand_key_reg(), 6'd1);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_DECRYPT, make_block('1, '1, '1, '1));
        wait_for_idle();

        load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                        rand_key_reg(), 6'd5);
        send_item(OP_EXPAND, rand_block());
        send_item(OP_ENCRYPT, rand_block());
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while blocks keep coming,
    // so the core fills up and stalls its input.
    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                        rand_key_reg(), 6'd24);
        send_item(OP_EXPAND, rand_block());
        hold_off_request = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_item(($urandom_range(1) != 0) ? OP_ENCRYPT : OP_DECRYPT, rand_block());
        end
        wait_for_idle();
    endtask

    // Each phase starts with a fresh key and an expansion, then mostly
    // blocks, with round trips, re-expansions and ignored codes mixed in.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int                   blocks_sent;
        int                   pick;
        logic [KEY_LEN_W-1:0] len;
        for (int setting = 0; setting < 2; setting++) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            case ($urandom_range(3))
                0: len = 6'd16;
                1: len = 6'd32;
                default: len = KEY_LEN_W'($urandom_range(63));
            endcase
            load_key_config(rand_key_reg(), rand_key_reg(), rand_key_reg(),
                            rand_key_reg(), len);
            sender_idle_pct    = idle_pct;
            receiver_stall_pct = stall_pct;
            send_item(OP_EXPAND, rand_block());
            blocks_sent = 1;
            while (blocks_sent < PHASE_BLOCKS) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    send_item(OP_EXPAND, rand_block());
                    blocks_sent++;
                end else if (pick < 7) begin
                    send_item(OP_UNUSED, rand_block());
                end else if (pick < 22) begin
                    send_item(OP_DECRYPT, last_ciphertext);
                    blocks_sent++;
                end else begin
                    send_item(($urandom_range(1) != 0) ? OP_ENCRYPT : OP_DECRYPT,
                              rand_block());
                    blocks_sent++;
                end
            end
            wait_for_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side, result checking and run limit
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_left    = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        block_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result %h %h %h %h", o_result_word_0,
                             o_result_word_1, o_result_word_2, o_result_word_3);
                end
            end else begin
                want = expected_blocks.pop_front();
                if (want.word0 !== o_result_word_0 || want.word1 !== o_result_word_1 ||
                    want.word2 !== o_result_word_2 || want.word3 !== o_result_word_3) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected %h %h %h %h, got %h %h %h %h",
                                 want.word0, want.word1, want.word2, want.word3,
                                 o_result_word_0, o_result_word_1,
                                 o_result_word_2, o_result_word_3);
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
                $display("rc6_block_cipher_core_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int k = 0; k < 4; k++) begin
            key_bytes[k] = '0;
        end
        for (int k = 0; k < TABLE_WORDS; k++) begin
            round_keys[k] = '0;
        end
        key_len         = KEY_LEN_RESET;
        last_ciphertext = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unkeyed_blocks();
        test_unused_operation();
        test_key_length_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(63, 0);
        test_output_hold_off();
        test_random_traffic(0, 63);
        test_random_traffic(8, 8);

        wait_for_idle();
        if (mismatch_count == 0 && expected_blocks.size() == 0) begin
            $display("rc6_block_cipher_core_tb OK");
        end else begin
            $display("rc6_block_cipher_core_tb NOT OK");
        end
        $finish;
    end

endmodule
